/* src/rlc_pkg.sv */
`default_nettype none

package rlc_pkg;

    // Event commands.
    localparam logic [2:0] CMD_LISTEN      = 3'd0;
    localparam logic [2:0] CMD_CONNECT     = 3'd1;
    localparam logic [2:0] CMD_CLOSE       = 3'd2;
    localparam logic [2:0] CMD_FINAL_CLOSE = 3'd3;
    localparam logic [2:0] CMD_SEND_DATA   = 3'd4;
    localparam logic [2:0] CMD_RECEIVE     = 3'd5;
    localparam logic [2:0] CMD_RETRY       = 3'd6;

    // Received segment types.
    localparam logic [2:0] SEG_SYN    = 3'd0;
    localparam logic [2:0] SEG_ACK    = 3'd1;
    localparam logic [2:0] SEG_SYNACK = 3'd2;
    localparam logic [2:0] SEG_NUL    = 3'd3;
    localparam logic [2:0] SEG_RST    = 3'd4;
    localparam logic [2:0] SEG_RSTACK = 3'd5;
    localparam logic [2:0] SEG_EACK   = 3'd6;

    // Transmitted segment kinds.
    localparam logic [2:0] KIND_SYN     = 3'd0;
    localparam logic [2:0] KIND_SYNACK  = 3'd1;
    localparam logic [2:0] KIND_ACK     = 3'd2;
    localparam logic [2:0] KIND_ACKDATA = 3'd3;
    localparam logic [2:0] KIND_RST     = 3'd4;
    localparam logic [2:0] KIND_RSTACK  = 3'd5;

    // Bit positions in the notification flags.
    localparam int FLAG_AW_START  = 0;
    localparam int FLAG_AW_DONE   = 1;
    localparam int FLAG_CW_START  = 2;
    localparam int FLAG_CONNECTED = 3;
    localparam int FLAG_CLOSED    = 4;
    localparam int FLAG_DELIVER   = 5;

    localparam logic [31:0] INIT_SEQ_RESET = 32'd1;

    // One incoming event request.
    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  seg_type;
        logic [7:0]  seg_src_port;
        logic [7:0]  seg_dst_port;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_data_length;
        logic [7:0]  local_port_req;
        logic [7:0]  remote_port_req;
    } t_event;

    // One result request.
    typedef struct packed {
        logic        accepted;
        logic        send_valid;
        logic [2:0]  send_kind;
        logic [31:0] send_seq;
        logic [31:0] send_ack;
        logic [7:0]  send_src_port;
        logic [7:0]  send_dst_port;
        logic [5:0]  notify_flags;
        logic [31:0] timer_seq;
        logic [2:0]  state_now;
        logic        can_send;
    } t_result;

    // Handshake between the input stage and the connection logic.
    typedef struct packed {
        logic   valid;
        t_event item;
    } t_in_stage;

endpackage

`default_nettype wire

/* src/rlc_in_stage.sv */
`default_nettype none

module rlc_in_stage
    import rlc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_event    i_item,
    output logic           o_in_stall,
    input  wire logic      i_advance,
    output t_in_stage      o_stage
);

    logic   r_valid;
    t_event r_item;

    // The held request blocks new ones only when the next stage cannot take it.
    assign o_in_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload is loaded only when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

/* src/rlc_conn_fsm.sv */
`default_nettype none

module rlc_conn_fsm
    import rlc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire t_in_stage   i_stage,
    output logic             o_advance,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_result          o_result
);

    typedef enum logic [2:0] {
        ST_CLOSED     = 3'd0,
        ST_LISTEN     = 3'd1,
        ST_SYN_SENT   = 3'd2,
        ST_SYN_RCVD   = 3'd3,
        ST_OPEN       = 3'd4,
        ST_ACTIVE_CW  = 3'd5,
        ST_PASSIVE_CW = 3'd6
    } t_state;

    typedef struct packed {
        t_state      conn_state;
        logic [7:0]  own_port;
        logic [7:0]  peer_port;
        logic [31:0] next_send_seq;
        logic [31:0] unacked_seq;
        logic [31:0] current_recv_seq;
        logic [31:0] last_delivered_seq;
        logic [2:0]  last_sent_kind;
        logic [31:0] last_sent_seq;
        logic [31:0] last_sent_ack;
        logic [15:0] last_sent_ports;
        logic        last_sent_valid;
    } t_conn_regs;

    t_conn_regs  r_conn;
    t_conn_regs  n_conn;
    logic [31:0] r_init_seq;
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;

    // Record a descriptor as the last one sent.
    function automatic t_conn_regs f_emit(t_conn_regs s, logic [2:0] kind,
                                          logic [31:0] ack);
        t_conn_regs t;
        t = s;
        t.last_sent_kind  = kind;
        t.last_sent_seq   = s.next_send_seq;
        t.last_sent_ack   = ack;
        t.last_sent_ports = {s.own_port, s.peer_port};
        t.last_sent_valid = 1'b1;
        return t;
    endfunction

    // A descriptor that must be acknowledged advances the send numbers.
    function automatic t_conn_regs f_track(t_conn_regs s);
        t_conn_regs t;
        t = s;
        t.unacked_seq   = s.next_send_seq;
        t.next_send_seq = s.next_send_seq + 32'd1;
        return t;
    endfunction

    assign o_advance = !r_out_valid || !i_out_stall;

    // Next connection state and result for the held event.
    always_comb begin
        t_event      ev;
        logic        ok;
        logic        txv;
        logic [5:0]  flags;
        logic [31:0] tseq;
        logic        ack_hit;
        logic        ack_pass;
        logic        port_bad;

        ev       = i_stage.item;
        n_conn   = r_conn;
        ok       = 1'b0;
        txv      = 1'b0;
        flags    = '0;
        tseq     = '0;
        ack_hit  = (r_conn.unacked_seq == ev.seg_ack);
        ack_pass = ack_hit || (r_conn.unacked_seq == r_init_seq);
        port_bad = (ev.seg_src_port != r_conn.peer_port) ||
                   (ev.seg_dst_port != r_conn.own_port);

        case (ev.command)
            CMD_LISTEN: begin
                if (r_conn.conn_state == ST_CLOSED) begin
                    n_conn.next_send_seq = r_init_seq + 32'd1;
                    n_conn.unacked_seq   = r_init_seq;
                    n_conn.own_port      = ev.local_port_req;
                    n_conn.conn_state    = ST_LISTEN;
                    ok = 1'b1;
                end
            end
            CMD_CONNECT: begin
                if (r_conn.conn_state == ST_CLOSED) begin
                    n_conn.own_port      = ev.local_port_req;
                    n_conn.peer_port     = ev.remote_port_req;
                    n_conn.conn_state    = ST_SYN_SENT;
                    n_conn.next_send_seq = r_init_seq + 32'd1;
                    n_conn = f_emit(n_conn, KIND_SYN, 32'd0);
                    tseq   = n_conn.next_send_seq;
                    n_conn = f_track(n_conn);
                    txv = 1'b1;
                    flags[FLAG_AW_START] = 1'b1;
                    ok = 1'b1;
                end
            end
            CMD_CLOSE: begin
                if (r_conn.conn_state == ST_OPEN) begin
                    n_conn.conn_state = ST_ACTIVE_CW;
                    n_conn = f_emit(n_conn, KIND_RST, r_conn.current_recv_seq);
                    tseq   = n_conn.next_send_seq;
                    n_conn = f_track(n_conn);
                    txv = 1'b1;
                    flags[FLAG_AW_START] = 1'b1;
                    flags[FLAG_CW_START] = 1'b1;
                    ok = 1'b1;
                end
            end
            CMD_FINAL_CLOSE: begin
                if (r_conn.conn_state == ST_CLOSED) begin
                    ok = 1'b1;
                end else if (r_conn.conn_state == ST_ACTIVE_CW ||
                             r_conn.conn_state == ST_PASSIVE_CW) begin
                    n_conn.conn_state = ST_CLOSED;
                    flags[FLAG_CLOSED] = 1'b1;
                    ok = 1'b1;
                end
            end
            CMD_SEND_DATA: begin
                if (r_conn.conn_state == ST_OPEN && r_conn.unacked_seq == r_init_seq) begin
                    n_conn = f_emit(n_conn, KIND_ACKDATA, r_conn.current_recv_seq);
                    tseq   = n_conn.next_send_seq;
                    n_conn = f_track(n_conn);
                    txv = 1'b1;
                    flags[FLAG_AW_START] = 1'b1;
                    ok = 1'b1;
                end
            end
            CMD_RECEIVE: begin
                if (ev.seg_type == SEG_SYN) begin
                    // A SYN only needs the destination port to match.
                    if (ev.seg_dst_port == r_conn.own_port &&
                        (r_conn.conn_state == ST_LISTEN ||
                         r_conn.conn_state == ST_SYN_SENT)) begin
                        if (r_conn.conn_state == ST_LISTEN) begin
                            n_conn.peer_port = ev.seg_src_port;
                        end
                        n_conn.conn_state       = ST_SYN_RCVD;
                        n_conn.current_recv_seq = ev.seg_seq;
                        n_conn.next_send_seq    = r_init_seq + 32'd1;
                        n_conn = f_emit(n_conn, KIND_SYNACK, ev.seg_seq);
                        tseq   = n_conn.next_send_seq;
                        n_conn = f_track(n_conn);
                        txv = 1'b1;
                        flags[FLAG_AW_START] = 1'b1;
                        ok = 1'b1;
                    end
                end else if (!port_bad) begin
                    case (ev.seg_type)
                        SEG_ACK: begin
                            if (ack_pass) begin
                                if (ack_hit) begin
                                    n_conn.unacked_seq = r_init_seq;
                                    flags[FLAG_AW_DONE] = 1'b1;
                                    tseq = ev.seg_ack;
                                end
                                n_conn.current_recv_seq = ev.seg_seq;
                                if (ev.seg_data_length != 16'd0) begin
                                    if (r_conn.conn_state == ST_OPEN) begin
                                        if (ev.seg_seq > r_conn.last_delivered_seq) begin
                                            flags[FLAG_DELIVER] = 1'b1;
                                        end
                                        n_conn.last_delivered_seq = ev.seg_seq;
                                        n_conn = f_emit(n_conn, KIND_ACK, ev.seg_seq);
                                        txv = 1'b1;
                                        ok = 1'b1;
                                    end
                                end else if (r_conn.conn_state == ST_SYN_RCVD) begin
                                    n_conn.conn_state = ST_OPEN;
                                    flags[FLAG_CONNECTED] = 1'b1;
                                    ok = 1'b1;
                                end else if (r_conn.conn_state == ST_OPEN) begin
                                    ok = 1'b1;
                                end else if (r_conn.conn_state == ST_PASSIVE_CW) begin
                                    n_conn.conn_state = ST_CLOSED;
                                    flags[FLAG_CLOSED] = 1'b1;
                                    ok = 1'b1;
                                end
                            end
                        end
                        SEG_SYNACK: begin
                            if (r_conn.conn_state == ST_OPEN ||
                                r_conn.conn_state == ST_SYN_SENT) begin
                                // State and receive number change even if the
                                // acknowledgement check fails.
                                n_conn.conn_state       = ST_OPEN;
                                n_conn.current_recv_seq = ev.seg_seq;
                                if (ack_hit) begin
                                    n_conn.unacked_seq = r_init_seq;
                                    flags[FLAG_AW_DONE] = 1'b1;
                                    tseq = ev.seg_ack;
                                end
                                if (ack_pass) begin
                                    n_conn = f_emit(n_conn, KIND_ACK, ev.seg_seq);
                                    txv = 1'b1;
                                    flags[FLAG_CONNECTED] = 1'b1;
                                    ok = 1'b1;
                                end
                            end else if (r_conn.conn_state == ST_SYN_RCVD) begin
                                n_conn.conn_state = ST_OPEN;
                                if (ack_hit) begin
                                    n_conn.unacked_seq = r_init_seq;
                                    flags[FLAG_AW_DONE] = 1'b1;
                                    tseq = ev.seg_ack;
                                end
                                if (ack_pass) begin
                                    n_conn.current_recv_seq = ev.seg_seq;
                                    flags[FLAG_CONNECTED] = 1'b1;
                                    ok = 1'b1;
                                end
                            end
                        end
                        SEG_NUL: begin
                            if (r_conn.conn_state == ST_OPEN) begin
                                n_conn.current_recv_seq = ev.seg_seq;
                                n_conn = f_emit(n_conn, KIND_ACK, ev.seg_seq);
                                txv = 1'b1;
                                ok = 1'b1;
                            end
                        end
                        SEG_RST: begin
                            if (r_conn.conn_state == ST_OPEN) begin
                                n_conn.current_recv_seq = ev.seg_seq;
                                n_conn.conn_state       = ST_PASSIVE_CW;
                                n_conn = f_emit(n_conn, KIND_RSTACK, ev.seg_seq);
                                tseq   = n_conn.next_send_seq;
                                n_conn = f_track(n_conn);
                                txv = 1'b1;
                                flags[FLAG_AW_START] = 1'b1;
                                flags[FLAG_CW_START] = 1'b1;
                                ok = 1'b1;
                            end else if (r_conn.conn_state == ST_ACTIVE_CW) begin
                                n_conn.conn_state = ST_CLOSED;
                                flags[FLAG_CLOSED] = 1'b1;
                                ok = 1'b1;
                            end else if (r_conn.conn_state == ST_PASSIVE_CW) begin
                                // Resend RSTACK; the timer value is the new one.
                                n_conn = f_emit(n_conn, KIND_RSTACK,
                                                r_conn.current_recv_seq);
                                tseq   = n_conn.next_send_seq;
                                n_conn = f_track(n_conn);
                                txv = 1'b1;
                                flags[FLAG_AW_DONE]  = 1'b1;
                                flags[FLAG_AW_START] = 1'b1;
                                ok = 1'b1;
                            end
                        end
                        SEG_RSTACK: begin
                            if (ack_pass) begin
                                if (ack_hit) begin
                                    n_conn.unacked_seq = r_init_seq;
                                    flags[FLAG_AW_DONE] = 1'b1;
                                    tseq = ev.seg_ack;
                                end
                                n_conn.current_recv_seq = ev.seg_seq;
                                if (r_conn.conn_state == ST_ACTIVE_CW) begin
                                    n_conn.conn_state = ST_CLOSED;
                                    n_conn = f_emit(n_conn, KIND_ACK, ev.seg_seq);
                                    txv = 1'b1;
                                    flags[FLAG_CLOSED] = 1'b1;
                                    ok = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // EACK and unknown types are rejected unchanged.
                            ok = 1'b0;
                        end
                    endcase
                end
            end
            CMD_RETRY: begin
                txv = r_conn.last_sent_valid;
                ok  = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        // Assemble the result; unused fields read as zero.
        n_result               = '0;
        n_result.accepted      = ok;
        if (txv) begin
            n_result.send_valid    = 1'b1;
            n_result.send_kind     = n_conn.last_sent_kind;
            n_result.send_seq      = n_conn.last_sent_seq;
            n_result.send_ack      = n_conn.last_sent_ack;
            n_result.send_src_port = n_conn.last_sent_ports[15:8];
            n_result.send_dst_port = n_conn.last_sent_ports[7:0];
        end
        n_result.notify_flags  = flags;
        n_result.timer_seq     = (flags[FLAG_AW_START] || flags[FLAG_AW_DONE]) ? tseq : '0;
        n_result.state_now     = n_conn.conn_state;
        n_result.can_send      = (n_conn.conn_state == ST_OPEN) &&
                                 (n_conn.unacked_seq == r_init_seq);
    end

    // Connection state, configuration and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn      <= '{conn_state: ST_CLOSED, default: '0};
            r_init_seq  <= INIT_SEQ_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_init_seq <= i_cfg_wr_data;
            end
            if (o_advance) begin
                r_out_valid <= i_stage.valid;
                if (i_stage.valid) begin
                    r_conn   <= n_conn;
                    r_result <= n_result;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // An unsent descriptor leaves its fields at zero.
    a_idle_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.send_valid |-> r_result.send_seq == '0 &&
            r_result.send_kind == '0 && r_result.send_ack == '0)
        else $error("descriptor fields set without send_valid");

    // The closed notification always leaves the connection closed.
    a_closed_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.notify_flags[FLAG_CLOSED] |->
            r_result.state_now == ST_CLOSED && r_conn.conn_state == ST_CLOSED)
        else $error("closed flag without closed state");

    // Sending is only allowed while open.
    a_can_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.can_send |-> r_result.state_now == ST_OPEN)
        else $error("can_send outside of open state");

    // A rejected event never transmits a segment.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.accepted |-> !r_result.send_valid)
        else $error("segment sent for a rejected event");

endmodule

`default_nettype wire

/* src/reliable_link_connection_fsm_top.sv */
// A request taken into the input register is processed into the result
// register, whose contents drive the outputs.
// Throughput: one event per cycle while the output is not stalled; the
// connection update is a single pass from input to result register.
// Reset: synchronous, active low; the connection goes to CLOSED, all numbers
// clear, and the initial send sequence returns to 1.
`default_nettype none

module reliable_link_connection_fsm_top
    import rlc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [2:0]  i_seg_type,
    input  wire logic [7:0]  i_seg_src_port,
    input  wire logic [7:0]  i_seg_dst_port,
    input  wire logic [31:0] i_seg_seq,
    input  wire logic [31:0] i_seg_ack,
    input  wire logic [15:0] i_seg_data_length,
    input  wire logic [7:0]  i_local_port_req,
    input  wire logic [7:0]  i_remote_port_req,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_accepted,
    output logic             o_send_valid,
    output logic [2:0]       o_send_kind,
    output logic [31:0]      o_send_seq,
    output logic [31:0]      o_send_ack,
    output logic [7:0]       o_send_src_port,
    output logic [7:0]       o_send_dst_port,
    output logic [5:0]       o_notify_flags,
    output logic [31:0]      o_timer_seq,
    output logic [2:0]       o_state_now,
    output logic             o_can_send
);

    t_event    w_item;
    t_in_stage w_stage;
    t_result   w_result;
    logic      w_advance;

    // Gather the request fields.
    assign w_item.command         = i_command;
    assign w_item.seg_type        = i_seg_type;
    assign w_item.seg_src_port    = i_seg_src_port;
    assign w_item.seg_dst_port    = i_seg_dst_port;
    assign w_item.seg_seq         = i_seg_seq;
    assign w_item.seg_ack         = i_seg_ack;
    assign w_item.seg_data_length = i_seg_data_length;
    assign w_item.local_port_req  = i_local_port_req;
    assign w_item.remote_port_req = i_remote_port_req;

    rlc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_item),
        .o_in_stall (o_in_stall),
        .i_advance  (w_advance),
        .o_stage    (w_stage)
    );

    rlc_conn_fsm u_conn_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stage       (w_stage),
        .o_advance     (w_advance),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (w_result)
    );

    // Split the result onto its ports.
    assign o_accepted      = w_result.accepted;
    assign o_send_valid    = w_result.send_valid;
    assign o_send_kind     = w_result.send_kind;
    assign o_send_seq      = w_result.send_seq;
    assign o_send_ack      = w_result.send_ack;
    assign o_send_src_port = w_result.send_src_port;
    assign o_send_dst_port = w_result.send_dst_port;
    assign o_notify_flags  = w_result.notify_flags;
    assign o_timer_seq     = w_result.timer_seq;
    assign o_state_now     = w_result.state_now;
    assign o_can_send      = w_result.can_send;

endmodule

`default_nettype wire
